>>> hdl/kte_pkg.sv
// kte_pkg: shared types and constants for the keyed table with expiry.
// Used by kte_match and keyed_table_with_ttl_expiry_core; no dependencies.
`default_nettype none

package kte_pkg;

    // default geometry
    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_BYTES_DEF = 8;

    // fixed item field widths
    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 64;
    localparam int LEN_W    = 4;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 8;

    localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd2;

    // opcodes
    localparam logic [OP_W-1:0] OP_FIND_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TTL  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_SWEEP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWEPT = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [KEY_IN_W-1:0] key;
        logic [LEN_W-1:0]    key_length;
        logic [TIME_W-1:0]   ttl;
        logic [TIME_W-1:0]   now;
    } kte_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  expired_count;
    } kte_rsp_t;

    // per-entry evaluation from the compare unit
    typedef struct packed {
        logic valid;
        logic hit;
        logic expired;
    } kte_eval_t;

endpackage

`default_nettype wire

>>> hdl/kte_ram.sv
// kte_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/kte_match.sv
// kte_match: compares one stored entry word with the item's key and time.
// Depends on kte_pkg.
`default_nettype none

module kte_match
    import kte_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic [KEY_BYTES*8+LEN_W+TIME_W:0] entry,
    input  wire logic [KEY_BYTES*8-1:0]            key,
    input  wire logic [LEN_W-1:0]                  key_length,
    input  wire logic [TIME_W-1:0]                 now,
    output kte_eval_t                              eval,
    output logic      [KEY_BYTES*8-1:0]            key_masked
);

    localparam int KEY_W   = KEY_BYTES * 8;
    localparam int WORD_W  = 1 + KEY_W + LEN_W + TIME_W;
    localparam int LEN_LO  = TIME_W;
    localparam int KEY_LO  = TIME_W + LEN_W;

    logic [KEY_W-1:0]  e_key;
    logic [LEN_W-1:0]  e_len;
    logic [TIME_W-1:0] e_exp;
    logic [KEY_BYTES-1:0] byte_eq;

    assign e_key = entry[KEY_LO +: KEY_W];
    assign e_len = entry[LEN_LO +: LEN_W];
    assign e_exp = entry[TIME_W-1:0];

    // byte b takes part when it lies below the key length
    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (key_length > LEN_W'(b))
            begin
                key_masked[b*8 +: 8] = key[b*8 +: 8];
                byte_eq[b]           = (e_key[b*8 +: 8] == key[b*8 +: 8]);
            end
            else
            begin
                key_masked[b*8 +: 8] = 8'd0;
                byte_eq[b]           = 1'b1;
            end
        end
    end

    assign eval.valid   = entry[WORD_W-1];
    assign eval.hit     = entry[WORD_W-1] && (e_len == key_length) && (&byte_eq);
    assign eval.expired = (e_exp != '0) && (e_exp < now);

endmodule

`default_nettype wire

>>> hdl/keyed_table_with_ttl_expiry_core.sv
// keyed_table_with_ttl_expiry_core: session table with per-entry expiry.
// Depends on kte_pkg, kte_ram and kte_match.
//
// Usage notes:
//  - Request channel (req_valid / req_stall / req): one item per operation.
//    The block takes one item at a time; req_stall is high while an item is
//    in progress and during the clearing pass after reset.
//  - Response channel (rsp_valid / rsp_stall / rsp): exactly one item per
//    request, held in an output register. A stalled response does not stop
//    the next request being taken; the block only waits at the end of that
//    next item if the earlier response is still not taken.
//  - Config channel (cfg_valid / cfg_ready / cfg_data): writes
//    sweep_interval, always ready. Write only while idle.
//  - All table state sits in one RAM word per entry (valid, key, length,
//    expiry), read one entry per cycle through the compare unit.
//  - Steps per item: acceptance, a search pass over every entry, then a
//    write-back where an entry changes and loading the response. A
//    find-or-add miss that triggers an expiry sweep runs a second pass;
//    an explicit sweep runs only the sweep pass. The single RAM read port
//    sets the pace of both passes.
//  - Reset: a clearing pass writes every entry empty, with requests
//    stalled; last sweep time resets to 0, interval to 2.
`default_nettype none

module keyed_table_with_ttl_expiry_core
    import kte_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire kte_req_t         req,
    // response channel
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output kte_rsp_t              rsp,
    // configuration write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int KEY_W  = KEY_BYTES * 8;
    localparam int WORD_W = 1 + KEY_W + LEN_W + TIME_W;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_SWEEP,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // scan pointer and read-data tracking
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    // current item and timing state
    kte_req_t         req_reg, req_next;
    logic             due_reg, due_next;
    logic [CFG_W-1:0] interval_reg, interval_next;
    logic [TIME_W-1:0] last_sweep_reg, last_sweep_next;

    // search results
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [WORD_W-1:0] hit_word_reg, hit_word_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              fe_found_reg, fe_found_next;
    logic [IDX_W-1:0]  fe_idx_reg, fe_idx_next;

    // result being built and pending write-back
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   wr_word_reg, wr_word_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;

    // output register
    logic     rsp_valid_reg, rsp_valid_next;
    kte_rsp_t rsp_reg, rsp_next;

    // RAM port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    kte_eval_t         ev;
    logic [KEY_W-1:0]  key_masked;
    logic [TIME_W:0]   due_sum;
    logic              last_data;
    logic [WORD_W-1:0] add_word;
    logic [IDX_W+SLOT_W-1:0]  slot_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    kte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // match unit sees the entry read back last cycle and the held item
    kte_match #(
        .KEY_BYTES (KEY_BYTES)
    ) u_match (
        .entry      (ram_rdata),
        .key        (req_reg.key[KEY_W-1:0]),
        .key_length (req_reg.key_length),
        .now        (req_reg.now),
        .eval       (ev),
        .key_masked (key_masked)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // 33-bit test so the sum never wraps
    assign due_sum   = {1'b0, last_sweep_reg} + {{(TIME_W + 1 - CFG_W){1'b0}}, interval_reg};
    assign last_data = pend_reg && (pidx_reg == LAST_IDX);
    assign add_word  = {1'b1, key_masked, req_reg.key_length, req_reg.ttl};
    assign slot_ext  = {{SLOT_W{1'b0}}, slot_reg};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        req_next        = req_reg;
        due_next        = due_reg;
        interval_next   = interval_reg;
        last_sweep_next = last_sweep_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        fe_found_next   = fe_found_reg;
        fe_idx_next     = fe_idx_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        wr_word_next    = wr_word_reg;
        wr_idx_next     = wr_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg;
        ram_wdata       = wr_word_reg;

        if (cfg_valid)
        begin
            interval_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // read issue for both scan passes
        if ((state_reg == S_SEARCH || state_reg == S_SWEEP) && issue_reg)
        begin
            pend_next = 1'b1;
            pidx_next = addr_reg;
            if (addr_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    due_next        = (due_sum < {1'b0, req.now});
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    fe_found_next   = 1'b0;
                    count_next      = '0;
                    addr_next       = '0;
                    issue_next      = 1'b1;
                    state_next      = (req.opcode == OP_SWEEP) ? S_SWEEP : S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (pend_reg)
                begin
                    if (ev.hit && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_idx_next  = pidx_reg;
                        hit_word_next = ram_rdata;
                    end
                    if (!ev.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                    // lowest slot that is free once a sweep has run
                    if ((!ev.valid || ev.expired) && !fe_found_reg)
                    begin
                        fe_found_next = 1'b1;
                        fe_idx_next   = pidx_reg;
                    end
                end
                if (last_data)
                begin
                    if (found_next)
                    begin
                        status_next  = ST_HIT;
                        slot_next    = hit_idx_next;
                        wr_idx_next  = hit_idx_next;
                        wr_word_next = hit_word_next;
                        if (req_reg.opcode == OP_REMOVE)
                        begin
                            wr_word_next[WORD_W-1] = 1'b0;
                        end
                        else
                        begin
                            wr_word_next[TIME_W-1:0] = req_reg.ttl;
                        end
                        state_next = S_WRITE;
                    end
                    else if (req_reg.opcode == OP_FIND_ADD)
                    begin
                        if (due_reg)
                        begin
                            last_sweep_next = req_reg.now;
                            addr_next       = '0;
                            issue_next      = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        else if (free_found_next)
                        begin
                            status_next  = ST_ADDED;
                            slot_next    = free_idx_next;
                            wr_idx_next  = free_idx_next;
                            wr_word_next = add_word;
                            state_next   = S_WRITE;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            slot_next   = '0;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        status_next = ST_MISS;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                end
            end

            S_SWEEP:
            begin
                // write-back trails the read by one entry; only the unused read after the last entry shares its address
                if (pend_reg && ev.valid && ev.expired)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg;
                    ram_wdata = {1'b0, ram_rdata[WORD_W-2:0]};
                    count_next = count_reg + CNT_W'(1);
                end
                if (last_data)
                begin
                    if (req_reg.opcode == OP_SWEEP)
                    begin
                        status_next = ST_SWEPT;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else if (fe_found_reg)
                    begin
                        status_next  = ST_ADDED;
                        slot_next    = fe_idx_reg;
                        wr_idx_next  = fe_idx_reg;
                        wr_word_next = add_word;
                        state_next   = S_WRITE;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                end
            end

            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_idx_reg;
                ram_wdata  = wr_word_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.slot          = slot_ext[SLOT_W-1:0];
                    rsp_next.expired_count = count_ext[COUNT_W-1:0];
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            addr_reg       <= '0;
            issue_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            req_reg        <= '0;
            due_reg        <= 1'b0;
            interval_reg   <= INTERVAL_RESET;
            last_sweep_reg <= '0;
            found_reg      <= 1'b0;
            hit_idx_reg    <= '0;
            hit_word_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            fe_found_reg   <= 1'b0;
            fe_idx_reg     <= '0;
            status_reg     <= ST_MISS;
            slot_reg       <= '0;
            count_reg      <= '0;
            wr_word_reg    <= '0;
            wr_idx_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            pidx_reg       <= pidx_next;
            req_reg        <= req_next;
            due_reg        <= due_next;
            interval_reg   <= interval_next;
            last_sweep_reg <= last_sweep_next;
            found_reg      <= found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_word_reg   <= hit_word_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            fe_found_reg   <= fe_found_next;
            fe_idx_reg     <= fe_idx_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            wr_word_reg    <= wr_word_next;
            wr_idx_reg     <= wr_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

`default_nettype wire
